// ----- src/wfo_pkg.sv -----
// Shared types and codes for the wall-follow obstacle mode machine.
package wfo_pkg;

  localparam int VEL_W  = 14;
  localparam int DIST_W = 16;
  localparam int TICK_W = 32;

  typedef enum logic [2:0] {
    CMD_LEFT_ENC    = 3'd0,
    CMD_RIGHT_ENC   = 3'd1,
    CMD_MID_SONAR   = 3'd2,
    CMD_LEFT_SONAR  = 3'd3,
    CMD_RIGHT_SONAR = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [9:0]  near_dist;
    logic [9:0]  safe_dist;
    logic [15:0] turn_ticks;
    logic [11:0] lin_speed;
    logic [11:0] ang_speed;
  } cfg_t;

  // Forward-mode speed pair for the current side distance.
  typedef struct packed {
    logic                    hit;
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
  } fwd_t;

endpackage

// ----- src/wfo_fwd_speed.sv -----
// Piecewise-linear wall-following speeds from the side distance.
module wfo_fwd_speed import wfo_pkg::*; (
  input  logic signed [DIST_W-1:0] side,
  input  logic [11:0]              lin_speed,
  input  logic [11:0]              ang_speed,
  output fwd_t                     fwd
);

  // floor(t / 50) for t below 204800 (4096 * 50), by reciprocal multiply
  localparam logic [18:0] DIV50_RECIP = 19'd335545;

  function automatic logic [11:0] div50(input logic [17:0] t);
    logic [36:0] p;
    p = {19'b0, t} * {18'b0, DIV50_RECIP};
    return p[35:24];
  endfunction

  logic [6:0]         s7;
  logic [9:0]         s7x7;
  logic signed [10:0] xw;
  logic signed [10:0] xw_neg;
  logic [8:0]         mw;
  logic [11:0]        qw;
  logic signed [VEL_W-1:0] w;
  logic [8:0]         xl;
  logic [11:0]        ql;
  logic [13:0]        a3;
  logic               s_pos;
  logic               s_zero;

  assign s7     = side[6:0];
  assign s_pos  = !side[DIST_W-1] && (side != '0);
  assign s_zero = (side == '0);

  // W = round((7S - 350) * 256 / 25), odd-symmetric rounding
  assign s7x7   = {3'b0, s7} * 10'd7;
  assign xw     = $signed({1'b0, s7x7}) - 11'sd350;
  assign xw_neg = -xw;
  assign mw     = xw[10] ? xw_neg[8:0] : xw[8:0];
  assign qw     = div50({mw, 9'b0} + 18'd25);
  assign w      = xw[10] ? -$signed({2'b0, qw}) : $signed({2'b0, qw});

  // linear speed between 30 and 50: round((3S - 90) * 512 / 25)
  assign xl = {2'b0, s7} * 9'd3 - 9'd90;
  assign ql = div50({2'b0, xl[5:0], 10'b0} + 18'd25);

  assign a3 = {2'b0, ang_speed} * 14'd3 + 14'd2;

  always_comb begin
    fwd = '{hit: 1'b0, lin: '0, ang: '0};
    if (s_zero) begin
      fwd = '{hit: 1'b1, lin: $signed({2'b0, lin_speed}), ang: $signed({2'b0, a3[13:2]})};
    end else if (s_pos && side > 16'sd50 && side < 16'sd100) begin
      fwd = '{hit: 1'b1, lin: $signed({2'b0, lin_speed}), ang: w};
    end else if (s_pos && side > 16'sd30 && side < 16'sd50) begin
      fwd = '{hit: 1'b1, lin: $signed({2'b0, ql}), ang: w};
    end else if (s_pos && side < 16'sd30) begin
      fwd = '{hit: 1'b1, lin: '0, ang: w};
    end
  end

endmodule

// ----- src/wfo_core.sv -----
// Sensor state, encoder increments and the forward/reverse/turn mode machine.
module wfo_core import wfo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [2:0]              cmd,
  input  logic [TICK_W-1:0]       reading,
  input  cfg_t                    cfg,
  output logic                    res_valid,
  output logic signed [VEL_W-1:0] res_lin,
  output logic signed [VEL_W-1:0] res_ang,
  output logic [1:0]              res_mode
);

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_REV  = 2'd1,
    MODE_TURN = 2'd2
  } mode_t;

  mode_t mode, mode_next;
  logic [TICK_W-1:0] left_ticks, right_ticks, left_base, right_base;
  logic [TICK_W-1:0] left_inc, right_inc;
  logic signed [DIST_W-1:0] ahead_dist, side_dist;

  logic signed [DIST_W-1:0] dist_in, a_cur, s_cur;
  logic        run, near, far, latch;
  logic signed [TICK_W+1:0] turn_sum;
  logic        turn_done;
  fwd_t        fwd;

  assign dist_in = $signed(reading[DIST_W-1:0]);
  assign a_cur = (cmd == CMD_MID_SONAR)  ? dist_in : ahead_dist;
  assign s_cur = (cmd == CMD_LEFT_SONAR) ? dist_in : side_dist;

  assign run = step && (cmd == CMD_MID_SONAR || cmd == CMD_LEFT_SONAR ||
                        cmd == CMD_RIGHT_SONAR);

  assign near = !a_cur[DIST_W-1] && (a_cur != '0) &&
                (a_cur[DIST_W-2:0] < {5'b0, cfg.near_dist});
  assign far  = !a_cur[DIST_W-1] &&
                (a_cur[DIST_W-2:0] > {5'b0, cfg.safe_dist});

  // turn finished once right_inc - left_inc + turn_ticks <= 0
  assign turn_sum = $signed({{2{right_inc[TICK_W-1]}}, right_inc}) -
                    $signed({{2{left_inc[TICK_W-1]}}, left_inc}) +
                    $signed({18'b0, cfg.turn_ticks});
  assign turn_done = turn_sum[TICK_W+1] || (turn_sum == '0);

  wfo_fwd_speed u_fwd (
    .side      (s_cur),
    .lin_speed (cfg.lin_speed),
    .ang_speed (cfg.ang_speed),
    .fwd       (fwd)
  );

  always_comb begin
    mode_next = mode;
    res_valid = 1'b0;
    res_lin   = '0;
    res_ang   = '0;
    latch     = 1'b0;
    if (run) begin
      unique case (mode)
        MODE_FWD: begin
          if (near) begin
            mode_next = MODE_REV;
            res_valid = 1'b1;
          end else if (fwd.hit) begin
            res_valid = 1'b1;
            res_lin   = fwd.lin;
            res_ang   = fwd.ang;
          end
        end
        MODE_REV: begin
          if (a_cur == '0) begin
            res_valid = 1'b0;
          end else if (far) begin
            mode_next = MODE_TURN;
            latch     = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_lin   = -$signed({2'b0, cfg.lin_speed});
          end
        end
        MODE_TURN: begin
          res_valid = 1'b1;
          if (near) begin
            mode_next = MODE_REV;
          end else if (turn_done) begin
            mode_next = MODE_FWD;
          end else begin
            res_ang = -$signed({2'b0, cfg.ang_speed});
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  assign res_mode = mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_FWD;
      left_ticks  <= '0;
      right_ticks <= '0;
      left_base   <= '0;
      right_base  <= '0;
      left_inc    <= '0;
      right_inc   <= '0;
      ahead_dist  <= '0;
      side_dist   <= '0;
    end else if (step) begin
      mode <= mode_next;
      if (cmd == CMD_LEFT_ENC) begin
        left_ticks <= reading;
        left_inc   <= reading - left_base;
      end
      if (cmd == CMD_RIGHT_ENC) begin
        right_ticks <= reading;
        right_inc   <= reading - right_base;
      end
      if (cmd == CMD_MID_SONAR) begin
        ahead_dist <= dist_in;
      end
      if (cmd == CMD_LEFT_SONAR) begin
        side_dist <= dist_in;
      end
      // start of turn: encoder increments count from here
      if (latch) begin
        left_base  <= left_ticks;
        right_base <= right_ticks;
        left_inc   <= '0;
        right_inc  <= '0;
      end
    end
  end

endmodule

// ----- src/wall_follow_obstacle_fsm.sv -----
// Top level of the wall-follow obstacle mode machine.
//
//  channel   | signals                           | contents
//  ----------+-----------------------------------+-----------------------------------
//  s_axis    | tvalid tready tdata[31:0] tuser   | tdata: reading; tuser: command
//  m_axis    | tvalid tready tdata[31:0]         | lin_vel, ang_vel, mode_now, pad
//  cfg       | cfg_we cfg_index[2:0] cfg_data    | 0 near 1 safe 2 turn_ticks 3 lin 4 ang
//
// From input transaction to result: the item register feeds the
// mode machine and speed logic, which settle into the result register.
// One item per cycle sustained unless the result stalls; the state updates as
// each item advances, so consecutive items see each other's state without a bubble.
// A stalled result holds the item register; input ready drops only then.
// Synchronous reset restores the default registers, forward mode, zero state.
module wall_follow_obstacle_fsm import wfo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] reading
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] lin_vel, [27:14] ang_vel, [29:28] mode_now
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] REG_NEAR_DIST  = 3'd0;
  localparam logic [2:0] REG_SAFE_DIST  = 3'd1;
  localparam logic [2:0] REG_TURN_TICKS = 3'd2;
  localparam logic [2:0] REG_LIN_SPEED  = 3'd3;
  localparam logic [2:0] REG_ANG_SPEED  = 3'd4;

  cfg_t cfg;

  logic              in_valid;
  logic [2:0]        in_cmd;
  logic [TICK_W-1:0] in_reading;
  logic              adv;

  logic                    res_valid;
  logic signed [VEL_W-1:0] res_lin, res_ang;
  logic [1:0]              res_mode;

  logic signed [VEL_W-1:0] out_lin, out_ang;
  logic [1:0]              out_mode;

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{near_dist: 10'd30, safe_dist: 10'd50, turn_ticks: 16'd663,
               lin_speed: 12'd1229, ang_speed: 12'd2867};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEAR_DIST:  cfg.near_dist  <= cfg_data[9:0];
        REG_SAFE_DIST:  cfg.safe_dist  <= cfg_data[9:0];
        REG_TURN_TICKS: cfg.turn_ticks <= cfg_data;
        REG_LIN_SPEED:  cfg.lin_speed  <= cfg_data[11:0];
        REG_ANG_SPEED:  cfg.ang_speed  <= cfg_data[11:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd     <= s_axis_tuser;
      in_reading <= s_axis_tdata;
    end
  end

  wfo_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .cmd       (in_cmd),
    .reading   (in_reading),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_lin   (res_lin),
    .res_ang   (res_ang),
    .res_mode  (res_mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (adv && res_valid) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_lin  <= res_lin;
      out_ang  <= res_ang;
      out_mode <= res_mode;
    end
  end

  assign m_axis_tdata = {2'b00, out_mode, out_ang, out_lin};

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while item register is blocked");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && res_valid) |=> m_axis_tvalid)
    else $error("result lost between core and output register");

  a_encoder_silent: assert property (@(posedge clk) disable iff (rst)
    (adv && (in_cmd == CMD_LEFT_ENC || in_cmd == CMD_RIGHT_ENC)) |-> !res_valid)
    else $error("encoder transaction produced a velocity command");
`endif

endmodule

// ----- bench/wall_follow_obstacle_fsm_tb.sv -----
// Self-checking bench for the wall-follow obstacle mode machine.
module wall_follow_obstacle_fsm_tb;
  import wfo_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 260;
  localparam int SETTLE_MAX  = 20000;
  localparam int DRAIN_CYC   = 6;
  localparam int IDLE_PCT    = 27;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    M_FWD  = 2'd0,
    M_REV  = 2'd1,
    M_TURN = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    R_NEAR = 3'd0,
    R_SAFE = 3'd1,
    R_TURN = 3'd2,
    R_LIN  = 3'd3,
    R_ANG  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] rd;
  } sensor_t;

  typedef struct {
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
    mode_e                   mode;
  } vel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] reading
  logic [2:0]  s_axis_tuser = '0;   // [2:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [13:0] lin_vel, [27:14] ang_vel, [29:28] mode_now
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  wall_follow_obstacle_fsm u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Register copy and robot state as the block should hold them
  cfg_t        regs = '{near_dist: 10'd30, safe_dist: 10'd50, turn_ticks: 16'd663,
                        lin_speed: 12'd1229, ang_speed: 12'd2867};
  mode_e       bot_mode = M_FWD;
  logic [31:0] lt = '0, rt = '0, lb = '0, rb = '0;
  int          ahead = 0, side = 0;

  sensor_t     sensor_q[$];
  vel_t        vel_q[$];
  logic [31:0] gl = '0, gr = '0;
  bit          steady = 1'b0;
  int          n_items = 0, n_acc = 0, n_vel = 0, errors = 0;
  int          n_reverse = 0, n_turn = 0, n_done = 0;

  function automatic int rnd_div(input int num, input int den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  // Advance the robot state for one sensor event; return 1 with a velocity command
  function automatic bit step_robot(input logic [2:0] cmd, input logic [31:0] rd,
                                    output vel_t v);
    int     a, s, w, nd, sd, tt, ls, as;
    bit     near;
    longint d;
    logic [31:0] dr, dl;
    v.lin  = '0;
    v.ang  = '0;
    v.mode = M_FWD;
    case (cmd)
      CMD_LEFT_ENC: begin
        lt = rd;
        return 1'b0;
      end
      CMD_RIGHT_ENC: begin
        rt = rd;
        return 1'b0;
      end
      CMD_MID_SONAR:  ahead = int'($signed(rd[15:0]));
      CMD_LEFT_SONAR: side  = int'($signed(rd[15:0]));
      CMD_RIGHT_SONAR: ;
      default: return 1'b0;
    endcase
    nd = int'(regs.near_dist);
    sd = int'(regs.safe_dist);
    tt = int'(regs.turn_ticks);
    ls = int'(regs.lin_speed);
    as = int'(regs.ang_speed);
    a = ahead;
    s = side;
    near = (a > 0) && (a < nd);
    w = rnd_div((7 * s - 350) * 256, 25);
    case (bot_mode)
      M_FWD: begin
        if (near) begin
          bot_mode = M_REV;
          n_reverse++;
        end else if (s == 0) begin
          v.lin = VEL_W'(ls);
          v.ang = VEL_W'((3 * as + 2) >> 2);
        end else if (s > 50 && s < 100) begin
          v.lin = VEL_W'(ls);
          v.ang = VEL_W'(w);
        end else if (s > 30 && s < 50) begin
          v.lin = VEL_W'(rnd_div((3 * s - 90) * 512, 25));
          v.ang = VEL_W'(w);
        end else if (s > 0 && s < 30) begin
          v.ang = VEL_W'(w);
        end else begin
          return 1'b0;
        end
      end
      M_REV: begin
        if (a == 0) return 1'b0;
        if (a > sd) begin
          bot_mode = M_TURN;
          lb = lt;
          rb = rt;
          n_turn++;
          return 1'b0;
        end
        v.lin = VEL_W'(-ls);
      end
      M_TURN: begin
        dr = rt - rb;
        dl = lt - lb;
        d = longint'($signed(dr)) - longint'($signed(dl));
        if (near) begin
          bot_mode = M_REV;
          n_reverse++;
        end else if (d <= -longint'(tt)) begin
          bot_mode = M_FWD;
          n_done++;
        end else begin
          v.ang = VEL_W'(-as);
        end
      end
      default: return 1'b0;
    endcase
    v.mode = bot_mode;
    return 1'b1;
  endfunction

  // Sender: predict on each accepted transaction, then present the next item
  always @(posedge clk) begin : drv
    vel_t    nv;
    sensor_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_acc++;
        if (step_robot(s_axis_tuser, s_axis_tdata, nv)) vel_q.push_back(nv);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sensor_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          it = sensor_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.cmd;
          s_axis_tdata  <= it.rd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void chk(input string name, input int want, input int got);
    if (want != got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver: random stalls, compare every velocity command with the oldest prediction
  always @(posedge clk) begin : mon
    vel_t ev;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (m_axis_tvalid && m_axis_tready) begin
        n_vel++;
        if (vel_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected velocity command, expected none, got %h",
                     $time, m_axis_tdata);
          errors++;
        end else begin
          ev = vel_q.pop_front();
          chk("lin_vel", int'(ev.lin), int'($signed(m_axis_tdata[13:0])));
          chk("ang_vel", int'(ev.ang), int'($signed(m_axis_tdata[27:14])));
          chk("mode_now", int'(ev.mode), int'(m_axis_tdata[29:28]));
        end
      end
    end
  end

  task automatic push(input logic [2:0] cmd, input logic [31:0] rd);
    sensor_q.push_back('{cmd: cmd, rd: rd});
    if (cmd == CMD_LEFT_ENC) gl = rd;
    if (cmd == CMD_RIGHT_ENC) gr = rd;
    if (cmd <= CMD_RIGHT_SONAR) n_items++;
  endtask

  // Sonar distance in the low half, junk or zeros in the high half
  task automatic push_dist(input logic [2:0] cmd, input int d);
    logic [15:0] hi;
    hi = $urandom_range(1) ? 16'($urandom()) : 16'h0000;
    push(cmd, {hi, 16'(d)});
  endtask

  function automatic int side_pick();
    case ($urandom_range(9))
      0: return 0;
      1: return 30;
      2: return 50;
      3: return $urandom_range(1, 29);
      4: return $urandom_range(31, 49);
      5: return $urandom_range(51, 99);
      6: return $urandom_range(100, 1100);
      7: return -int'($urandom_range(1, 32768));
      8: return $urandom_range(1, 99);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int far_pick(input int nd);
    case ($urandom_range(7))
      0: return 0;
      1: return -int'($urandom_range(1, 32768));
      2: return 32767;
      default: return nd + $urandom_range(0, 600);
    endcase
  endfunction

  // Cruise, close in on an obstacle, back off, spin right until the ticks say done
  task automatic episode();
    int nd, sd, tt, a, step, acc;
    nd = int'(regs.near_dist);
    sd = int'(regs.safe_dist);
    tt = int'(regs.turn_ticks);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(3))
        0: push_dist(CMD_LEFT_SONAR, side_pick());
        1: push_dist(CMD_MID_SONAR, far_pick(nd));
        2: push_dist(CMD_RIGHT_SONAR, $urandom_range(0, 500));
        default: push(CMD_LEFT_ENC, gl + $urandom_range(0, 300));
      endcase
    end
    if (nd < 2) return;
    push_dist(CMD_MID_SONAR, $urandom_range(1, nd - 1));
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(3))
        0: push_dist(CMD_MID_SONAR, 0);
        1: push_dist(CMD_MID_SONAR, -int'($urandom_range(1, 32768)));
        2: push_dist(CMD_RIGHT_SONAR, $urandom_range(0, 100));
        default: push_dist(CMD_MID_SONAR, $urandom_range(1, sd > 0 ? sd : 1));
      endcase
    end
    a = ((sd + 1 > nd) ? sd + 1 : nd) + $urandom_range(0, 100);
    push_dist(CMD_MID_SONAR, a);
    if ($urandom_range(1)) push_dist(CMD_RIGHT_SONAR, $urandom_range(0, 100));
    acc = 0;
    do begin
      step = $urandom_range(1, tt / 4 + 2);
      if ($urandom_range(1)) push(CMD_LEFT_ENC, gl + step);
      else push(CMD_RIGHT_ENC, gr - step);
      acc += step;
      if ($urandom_range(19) == 0) begin
        push_dist(CMD_MID_SONAR, $urandom_range(1, nd - 1));
        return;
      end
      if ($urandom_range(1)) push_dist(CMD_RIGHT_SONAR, $urandom_range(0, 100));
      else push_dist(CMD_MID_SONAR, a);
    end while (acc < tt);
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 8)) push(3'($urandom_range(0, 7)), $urandom());
  endtask

  task automatic fill(input int count);
    int target;
    target = n_items + count;
    while (n_items < target) begin
      if ($urandom_range(99) < 75) episode();
      else noise();
    end
  endtask

  // Wait for the sender to drain and every command to arrive, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    while ((sensor_q.size() != 0 || s_axis_tvalid || vel_q.size() != 0) &&
           waited < SETTLE_MAX) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      R_NEAR:  regs.near_dist  = val[9:0];
      R_SAFE:  regs.safe_dist  = val[9:0];
      R_TURN:  regs.turn_ticks = val;
      R_LIN:   regs.lin_speed  = val[11:0];
      R_ANG:   regs.ang_speed  = val[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int nd, input int sd, input int tt, input int ls,
                          input int as);
    write_reg(R_NEAR, 16'(nd));
    write_reg(R_SAFE, 16'(sd));
    write_reg(R_TURN, 16'(tt));
    write_reg(R_LIN, 16'(ls));
    write_reg(R_ANG, 16'(as));
  endtask

  // Reset defaults: every side rule, reverse, turn start, wrapped encoders, turn done
  task automatic directed();
    push(CMD_LEFT_ENC, 32'h7FFF_FFFF);
    push(CMD_RIGHT_ENC, 32'h8000_0000);
    for (int c = CMD_RIGHT_SONAR + 1; c < 8; c++) push(3'(c), $urandom());
    push_dist(CMD_LEFT_SONAR, 0);
    push_dist(CMD_LEFT_SONAR, 30);
    push_dist(CMD_LEFT_SONAR, 50);
    push_dist(CMD_LEFT_SONAR, 100);
    push_dist(CMD_LEFT_SONAR, -1);
    push_dist(CMD_LEFT_SONAR, 29);
    push_dist(CMD_LEFT_SONAR, 31);
    push_dist(CMD_LEFT_SONAR, 51);
    push_dist(CMD_LEFT_SONAR, 99);
    push_dist(CMD_RIGHT_SONAR, 7);
    push_dist(CMD_MID_SONAR, -32768);
    push(CMD_MID_SONAR, 32'hFFFF_0014);
    push_dist(CMD_MID_SONAR, -5);
    push_dist(CMD_MID_SONAR, 0);
    push_dist(CMD_MID_SONAR, 50);
    push_dist(CMD_MID_SONAR, 51);
    push_dist(CMD_RIGHT_SONAR, 0);
    push(CMD_RIGHT_ENC, 32'h7FFF_FE70);
    push_dist(CMD_RIGHT_SONAR, 0);
    push(CMD_LEFT_ENC, 32'h8000_012B);
    push_dist(CMD_RIGHT_SONAR, 0);
  endtask

  initial begin : stim
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_regs(1023, 1023, 65535, 4095, 4095);
        2: set_regs(0, 0, 0, 0, 0);
        3: set_regs($urandom_range(2, 200), $urandom_range(0, 300),
                    $urandom_range(0, 5000), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
        4: set_regs($urandom_range(2, 100), $urandom_range(0, 150),
                    $urandom_range(0, 2000), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
        default: set_regs(1023, 0, 1, 4095, 1);
      endcase
      @(negedge clk);
      steady = (ph == 3);
      fill(PHASE_ITEMS / 2);
      settle();
      fill(PHASE_ITEMS / 2);
      settle();
    end
    if (vel_q.size() != 0) begin
      $display("%0t: %0d velocity commands never arrived", $time, vel_q.size());
      errors++;
    end
    $display("Fed %0d sensor transactions over %0d register settings, checked %0d commands",
             n_acc, PHASES, n_vel);
    $display("Reversals %0d, turns started %0d, turns completed %0d, mismatches %0d",
             n_reverse, n_turn, n_done, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
